FILE: sv/pairwise_gravity_kick_core_defines.svh
// Assertion macros shared by the pairwise gravity kick RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef PAIRWISE_GRAVITY_KICK_CORE_DEFINES_SVH
`define PAIRWISE_GRAVITY_KICK_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PGK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PGK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pgk_pkg.sv
// Shared constants and types for the pairwise gravity kick pipeline.
// No dependencies; used by pgk_isqrt, pgk_div, the top level and the testbench.
`default_nettype none

package pgk_pkg;

  // configuration reset values
  localparam logic [31:0] G_RESET   = 32'd6553600;  // 100.0 in Q16.16
  localparam logic [31:0] DT_RESET  = 32'd4294967;  // ~0.001 in Q0.32
  localparam logic [16:0] EPS_RESET = 17'd6554;     // ~0.1 in Q16.16

  // register index codes (paddr[3:2])
  localparam logic [1:0] REG_GRAV = 2'd0;
  localparam logic [1:0] REG_STEP = 2'd1;
  localparam logic [1:0] REG_SOFT = 2'd2;

  localparam int ADDR_W = 4;

  // arithmetic widths
  localparam int SQRT_STAGES = 32;   // one result bit per stage
  localparam int DIV_QW      = 35;   // quotient bits kept (cap is 2^34)
  localparam int NUM_W       = 112;  // K * |delta| * 2^16
  localparam int DEN_W       = 96;   // S * D
  localparam int DIV_LAT     = DIV_QW + 1;

  // front (4) + root + product/sum (2) + divider + output register
  localparam int PIPE_DEPTH = 4 + SQRT_STAGES + 2 + DIV_LAT + 1;

  localparam logic signed [31:0] VEL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VEL_MIN = 32'sh8000_0000;

  // velocities and direction signs riding along the pipeline
  typedef struct packed {
    logic [31:0] v1x;
    logic [31:0] v1y;
    logic [31:0] v2x;
    logic [31:0] v2y;
    logic        nx;   // second_x - first_x negative
    logic        ny;
  } vel_side_t;

  // operands that wait for the square root
  typedef struct packed {
    vel_side_t   vel;
    logic [31:0] adx;
    logic [31:0] ady;
    logic [63:0] k1;
    logic [63:0] k2;
    logic [63:0] s;
  } root_side_t;

endpackage

`default_nettype wire

FILE: sv/pgk_isqrt.sv
// Pipelined 64-bit integer square root, one result bit per stage.
// Depends on pgk_pkg for the stage count.
`default_nettype none

module pgk_isqrt
  import pgk_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] s_i,
  output logic      [31:0] d_o
);

  logic [63:0] x_r   [0:SQRT_STAGES-1];
  logic [63:0] res_r [0:SQRT_STAGES-1];
  logic [63:0] x_w   [0:SQRT_STAGES];
  logic [63:0] res_w [0:SQRT_STAGES];

  assign x_w[0]   = s_i;
  assign res_w[0] = 64'd0;

  // digit-by-digit root: stage j tries bit 2^(62-2j)
  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    logic [63:0] x_nxt;
    logic [63:0] res_nxt;

    assign trial = res_w[j] + BIT;

    always_comb begin
      if (x_w[j] >= trial) begin
        x_nxt   = x_w[j] - trial;
        res_nxt = (res_w[j] >> 1) + BIT;
      end else begin
        x_nxt   = x_w[j];
        res_nxt = res_w[j] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[j]   <= x_nxt;
        res_r[j] <= res_nxt;
      end
    end

    assign x_w[j+1]   = x_r[j];
    assign res_w[j+1] = res_r[j];
  end

  assign d_o = res_w[SQRT_STAGES][31:0];

endmodule

`default_nettype wire

FILE: sv/pgk_div.sv
// Pipelined restoring divider with quotient cap at 2^34, one bit per stage.
// Depends on pgk_pkg for operand and quotient widths.
`default_nettype none

module pgk_div
  import pgk_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  output logic      [DIV_QW-1:0] q_o
);

  localparam int CMP_W = DEN_W + DIV_QW;
  localparam logic [DIV_QW-1:0] KICK_CAP = {1'b1, {(DIV_QW-1){1'b0}}};

  logic [NUM_W-1:0]  rem_r  [0:DIV_QW];
  logic [DIV_QW-1:0] q_r    [0:DIV_QW];
  logic [DEN_W-1:0]  den_r  [0:DIV_QW-1];
  logic              cap_r  [0:DIV_QW];
  logic              zero_r [0:DIV_QW];

  // entry: quotient too large for DIV_QW bits saturates; zero divisor gives zero
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num_i;
      q_r[0]    <= '0;
      den_r[0]  <= den_i;
      cap_r[0]  <= CMP_W'(num_i) >= (CMP_W'(den_i) << DIV_QW);
      zero_r[0] <= den_i == '0;
    end
  end

  // stage i decides quotient bit DIV_QW-1-i
  for (genvar i = 0; i < DIV_QW; i++) begin : g_step
    localparam int B = DIV_QW - 1 - i;
    logic [CMP_W-1:0] trial;
    logic             take;

    assign trial = CMP_W'(den_r[i]) << B;
    assign take  = CMP_W'(rem_r[i]) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]  <= take ? (rem_r[i] - trial[NUM_W-1:0]) : rem_r[i];
        q_r[i+1]    <= q_r[i] | (take ? (DIV_QW'(1) << B) : '0);
        cap_r[i+1]  <= cap_r[i];
        zero_r[i+1] <= zero_r[i];
      end
    end

    if (i < DIV_QW - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[i+1] <= den_r[i];
        end
      end
    end
  end

  always_comb begin
    if (zero_r[DIV_QW]) begin
      q_o = '0;
    end else if (cap_r[DIV_QW] || q_r[DIV_QW] > KICK_CAP) begin
      q_o = KICK_CAP;
    end else begin
      q_o = q_r[DIV_QW];
    end
  end

endmodule

`default_nettype wire

FILE: sv/pairwise_gravity_kick_core.sv
// Top level of the pairwise softened gravity kick pipeline.
// Depends on pgk_pkg, pgk_isqrt, pgk_div and pairwise_gravity_kick_core_defines.svh.
//
//   channel | ports                         | transfer when
//   --------+-------------------------------+--------------------------------
//   input   | in_valid / in_stall / in_*    | in_valid && !in_stall
//   result  | out_valid / out_stall / out_* | out_valid && !out_stall
//   config  | psel penable pwrite paddr ... | psel && penable && pwrite
//
// One pair enters per cycle while no result is stalled; it passes 4 front stages,
// 32 square-root stages, 2 product stages, 36 divider stages and 1 output stage.
// The divider and the square root set the depth, one bit per stage each.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Synchronous active-low reset clears the valid bits and presets the config registers.
`default_nettype none
`include "pairwise_gravity_kick_core_defines.svh"

module pairwise_gravity_kick_core
  import pgk_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_first_x,
  input  wire logic signed [31:0] in_first_y,
  input  wire logic signed [31:0] in_first_vel_x,
  input  wire logic signed [31:0] in_first_vel_y,
  input  wire logic        [31:0] in_first_mass,
  input  wire logic signed [31:0] in_second_x,
  input  wire logic signed [31:0] in_second_y,
  input  wire logic signed [31:0] in_second_vel_x,
  input  wire logic signed [31:0] in_second_vel_y,
  input  wire logic        [31:0] in_second_mass,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_new_first_vel_x,
  output logic signed [31:0]      out_new_first_vel_y,
  output logic signed [31:0]      out_new_second_vel_x,
  output logic signed [31:0]      out_new_second_vel_y,
  output logic                    out_saturated
);

  // ---------------------------------------------------------------- config
  logic [31:0] grav_r;
  logic [31:0] step_r;
  logic [16:0] soft_r;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= G_RESET;
      step_r <= DT_RESET;
      soft_r <= EPS_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_GRAV: grav_r <= pwdata;
        REG_STEP: step_r <= pwdata;
        REG_SOFT: soft_r <= pwdata[16:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GRAV: prdata = grav_r;
      REG_STEP: prdata = step_r;
      REG_SOFT: prdata = {15'd0, soft_r};
      default:  prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- flow
  logic                  en;
  logic [PIPE_DEPTH-1:0] v_r;

  // whole pipeline advances unless a finished result is held
  assign en       = !(v_r[PIPE_DEPTH-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  assign out_valid = v_r[PIPE_DEPTH-1];

  // ---------------------------------------------------------------- stage 1
  // separations and their magnitudes
  logic [32:0] dx_w;
  logic [32:0] dy_w;
  logic [32:0] adx_w;
  logic [32:0] ady_w;

  assign dx_w  = {in_second_x[31], in_second_x} - {in_first_x[31], in_first_x};
  assign dy_w  = {in_second_y[31], in_second_y} - {in_first_y[31], in_first_y};
  assign adx_w = dx_w[32] ? (33'd0 - dx_w) : dx_w;
  assign ady_w = dy_w[32] ? (33'd0 - dy_w) : dy_w;

  logic [31:0] adx1_r, ady1_r, m1_1_r, m2_1_r;
  vel_side_t   vel1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      adx1_r     <= adx_w[31:0];
      ady1_r     <= ady_w[31:0];
      m1_1_r     <= in_first_mass;
      m2_1_r     <= in_second_mass;
      vel1_r.v1x <= in_first_vel_x;
      vel1_r.v1y <= in_first_vel_y;
      vel1_r.v2x <= in_second_vel_x;
      vel1_r.v2y <= in_second_vel_y;
      vel1_r.nx  <= dx_w[32];
      vel1_r.ny  <= dy_w[32];
    end
  end

  // ---------------------------------------------------------------- stage 2
  // squares and G times the other mass
  logic [31:0] adx2_r, ady2_r;
  logic [63:0] sqx2_r, sqy2_r, gm1_2_r, gm2_2_r;
  logic [33:0] eps2_r;
  vel_side_t   vel2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      adx2_r  <= adx1_r;
      ady2_r  <= ady1_r;
      sqx2_r  <= 64'(adx1_r) * 64'(adx1_r);
      sqy2_r  <= 64'(ady1_r) * 64'(ady1_r);
      eps2_r  <= 34'(soft_r) * 34'(soft_r);
      gm1_2_r <= 64'(grav_r) * 64'(m2_1_r);
      gm2_2_r <= 64'(grav_r) * 64'(m1_1_r);
      vel2_r  <= vel1_r;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // saturating S, partial products of (G m) * dt
  logic [65:0] ssum_w;
  logic [63:0] s3_r, kh1_3_r, kl1_3_r, kh2_3_r, kl2_3_r;
  logic [31:0] adx3_r, ady3_r;
  vel_side_t   vel3_r;

  assign ssum_w = {2'b00, sqx2_r} + {2'b00, sqy2_r} + {32'd0, eps2_r};

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r    <= (ssum_w[65:64] != 2'b00) ? {64{1'b1}} : ssum_w[63:0];
      kh1_3_r <= 64'(gm1_2_r[63:32]) * 64'(step_r);
      kl1_3_r <= 64'(gm1_2_r[31:0]) * 64'(step_r);
      kh2_3_r <= 64'(gm2_2_r[63:32]) * 64'(step_r);
      kl2_3_r <= 64'(gm2_2_r[31:0]) * 64'(step_r);
      adx3_r  <= adx2_r;
      ady3_r  <= ady2_r;
      vel3_r  <= vel2_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // strength K = floor(G m dt) in 2^-32 units
  root_side_t rs4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rs4_r.vel <= vel3_r;
      rs4_r.adx <= adx3_r;
      rs4_r.ady <= ady3_r;
      rs4_r.k1  <= kh1_3_r + {32'd0, kl1_3_r[63:32]};
      rs4_r.k2  <= kh2_3_r + {32'd0, kl2_3_r[63:32]};
      rs4_r.s   <= s3_r;
    end
  end

  // ---------------------------------------------------------------- root
  logic [31:0] d_w;
  root_side_t  rdly_r [0:SQRT_STAGES-1];

  pgk_isqrt u_isqrt (
    .clk (clk),
    .en  (en),
    .s_i (rs4_r.s),
    .d_o (d_w)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      rdly_r[0] <= rs4_r;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        rdly_r[i] <= rdly_r[i-1];
      end
    end
  end

  root_side_t rs_w;
  assign rs_w = rdly_r[SQRT_STAGES-1];

  // ---------------------------------------------------------------- products
  // lanes: 0 first x, 1 first y, 2 second x, 3 second y
  logic [63:0] lk_w [0:3];
  logic [31:0] la_w [0:3];

  assign lk_w[0] = rs_w.k1;
  assign lk_w[1] = rs_w.k1;
  assign lk_w[2] = rs_w.k2;
  assign lk_w[3] = rs_w.k2;
  assign la_w[0] = rs_w.adx;
  assign la_w[1] = rs_w.ady;
  assign la_w[2] = rs_w.adx;
  assign la_w[3] = rs_w.ady;

  logic [63:0] dh_r, dl_r;
  logic [63:0] nh_r [0:3];
  logic [63:0] nl_r [0:3];
  vel_side_t   vel37_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dh_r    <= 64'(rs_w.s[63:32]) * 64'(d_w);
      dl_r    <= 64'(rs_w.s[31:0]) * 64'(d_w);
      vel37_r <= rs_w.vel;
      for (int l = 0; l < 4; l++) begin
        nh_r[l] <= 64'(lk_w[l][63:32]) * 64'(la_w[l]);
        nl_r[l] <= 64'(lk_w[l][31:0]) * 64'(la_w[l]);
      end
    end
  end

  // partial product sums: den = S*D, num = K*|delta|*2^16
  logic [DEN_W-1:0] den38_r;
  logic [NUM_W-1:0] num38_r [0:3];
  vel_side_t        vel38_r;

  always_ff @(posedge clk) begin
    if (en) begin
      den38_r <= {dh_r, 32'd0} + {32'd0, dl_r};
      vel38_r <= vel37_r;
      for (int l = 0; l < 4; l++) begin
        num38_r[l] <= {({nh_r[l], 32'd0} + {32'd0, nl_r[l]}), 16'd0};
      end
    end
  end

  // ---------------------------------------------------------------- divide
  logic [DIV_QW-1:0] q_w [0:3];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    pgk_div u_div (
      .clk   (clk),
      .en    (en),
      .num_i (num38_r[l]),
      .den_i (den38_r),
      .q_o   (q_w[l])
    );
  end

  vel_side_t vdly_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      vdly_r[0] <= vel38_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        vdly_r[i] <= vdly_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- output
  // v +/- q with clamp to 32 bits; returns {clamped, value}
  function automatic logic [32:0] kick_apply(input logic [31:0] v,
                                             input logic [DIV_QW-1:0] q,
                                             input logic sub);
    logic [36:0] ve;
    logic [36:0] qe;
    logic [36:0] sum;
    ve  = {{5{v[31]}}, v};
    qe  = {2'b00, q};
    sum = sub ? (ve - qe) : (ve + qe);
    if (!sum[36] && sum[35:31] != 5'b00000) begin
      kick_apply = {1'b1, VEL_MAX};
    end else if (sum[36] && sum[35:31] != 5'b11111) begin
      kick_apply = {1'b1, VEL_MIN};
    end else begin
      kick_apply = {1'b0, sum[31:0]};
    end
  endfunction

  vel_side_t   vf_w;
  logic [32:0] r1x_w, r1y_w, r2x_w, r2y_w;

  assign vf_w  = vdly_r[DIV_LAT-1];
  assign r1x_w = kick_apply(vf_w.v1x, q_w[0], vf_w.nx);
  assign r1y_w = kick_apply(vf_w.v1y, q_w[1], vf_w.ny);
  assign r2x_w = kick_apply(vf_w.v2x, q_w[2], !vf_w.nx);
  assign r2y_w = kick_apply(vf_w.v2y, q_w[3], !vf_w.ny);

  logic [31:0] o1x_r, o1y_r, o2x_r, o2y_r;
  logic        osat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      o1x_r  <= r1x_w[31:0];
      o1y_r  <= r1y_w[31:0];
      o2x_r  <= r2x_w[31:0];
      o2y_r  <= r2y_w[31:0];
      osat_r <= r1x_w[32] | r1y_w[32] | r2x_w[32] | r2y_w[32];
    end
  end

  assign out_new_first_vel_x  = o1x_r;
  assign out_new_first_vel_y  = o1y_r;
  assign out_new_second_vel_x = o2x_r;
  assign out_new_second_vel_y = o2y_r;
  assign out_saturated        = osat_r;

  // ---------------------------------------------------------------- checks
  `PGK_ASSERT_NXT(a_hold_on_stall, out_valid && out_stall, $stable(v_r),
    "pipeline moved while result stalled")
  `PGK_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, v_r[0],
    "accepted transfer did not enter pipeline")
  `PGK_ASSERT_IMP(a_sat_at_limit, out_valid && out_saturated,
    out_new_first_vel_x == VEL_MAX || out_new_first_vel_x == VEL_MIN ||
    out_new_first_vel_y == VEL_MAX || out_new_first_vel_y == VEL_MIN ||
    out_new_second_vel_x == VEL_MAX || out_new_second_vel_x == VEL_MIN ||
    out_new_second_vel_y == VEL_MAX || out_new_second_vel_y == VEL_MIN,
    "saturated flag without a clamped velocity")
  `PGK_ASSERT_NXT(a_grav_write, cfg_wr && paddr[3:2] == REG_GRAV,
    grav_r == $past(pwdata), "gravity register write lost")

endmodule

`default_nettype wire

FILE: tb/gravity_kick_checker.sv
// Scoreboard for pairwise_gravity_kick_core: predicts each result from the accepted
// pair and the tracked register values, then compares transfers on the result port.
// Depends on pgk_pkg for register index codes, reset values and the address width.
module gravity_kick_checker
  import pgk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [31:0]       in_first_x,
  input  logic [31:0]       in_first_y,
  input  logic [31:0]       in_first_vel_x,
  input  logic [31:0]       in_first_vel_y,
  input  logic [31:0]       in_first_mass,
  input  logic [31:0]       in_second_x,
  input  logic [31:0]       in_second_y,
  input  logic [31:0]       in_second_vel_x,
  input  logic [31:0]       in_second_vel_y,
  input  logic [31:0]       in_second_mass,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [31:0]       out_new_first_vel_x,
  input  logic [31:0]       out_new_first_vel_y,
  input  logic [31:0]       out_new_second_vel_x,
  input  logic [31:0]       out_new_second_vel_y,
  input  logic              out_saturated,
  output int                mismatches,
  output int                kicks_pending
);

  typedef struct packed {
    logic [31:0] v1x;
    logic [31:0] v1y;
    logic [31:0] v2x;
    logic [31:0] v2y;
    logic        sat;
  } kicked_vel_t;

  localparam logic [127:0] KICK_CAP = 128'd1 << 34;

  kicked_vel_t kick_queue[$];
  logic [31:0] grav_q;
  logic [31:0] step_q;
  logic [16:0] soft_q;

  // floor square root, one result bit per pass
  function automatic logic [63:0] floor_root(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // G * m * dt in units of 2^-32
  function automatic logic [63:0] pull_strength(logic [31:0] mass);
    logic [63:0] gm;
    logic [63:0] hi;
    logic [63:0] lo;
    gm = {32'd0, grav_q} * {32'd0, mass};
    hi = {32'd0, gm[63:32]};
    lo = {32'd0, gm[31:0]};
    return hi * {32'd0, step_q} + ((lo * {32'd0, step_q}) >> 32);
  endfunction

  // per-axis velocity change magnitude, Q16.16, capped
  function automatic logic [63:0] kick_size(logic [63:0] k, logic [63:0] ad,
                                            logic [63:0] s, logic [63:0] d);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    if (s == 0 || ad == 0 || k == 0) return 0;
    num = ({64'd0, k} * {64'd0, ad}) << 16;
    den = {64'd0, s} * {64'd0, d};
    q = num / den;
    if (q > KICK_CAP) q = KICK_CAP;
    return q[63:0];
  endfunction

  function automatic logic [31:0] clamp_vel(longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
      sat = 1'b1;
    end
    if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
      sat = 1'b1;
    end
    return v[31:0];
  endfunction

  function automatic kicked_vel_t predict_kick();
    kicked_vel_t r;
    longint dx;
    longint dy;
    logic [63:0] adx;
    logic [63:0] ady;
    logic [64:0] acc;
    logic [63:0] s;
    logic [63:0] d;
    logic [63:0] k1;
    logic [63:0] k2;
    longint q1x;
    longint q1y;
    longint q2x;
    longint q2y;
    logic sat;
    dx = longint'($signed(in_second_x)) - longint'($signed(in_first_x));
    dy = longint'($signed(in_second_y)) - longint'($signed(in_first_y));
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    acc = {1'b0, adx * adx} + {1'b0, ady * ady};
    s = acc[64] ? '1 : acc[63:0];
    acc = {1'b0, s} + {1'b0, {47'd0, soft_q} * {47'd0, soft_q}};
    s = acc[64] ? '1 : acc[63:0];
    d = floor_root(s);
    k1 = pull_strength(in_second_mass);
    k2 = pull_strength(in_first_mass);
    q1x = kick_size(k1, adx, s, d);
    q1y = kick_size(k1, ady, s, d);
    q2x = kick_size(k2, adx, s, d);
    q2y = kick_size(k2, ady, s, d);
    if (dx < 0) begin
      q1x = -q1x;
      q2x = -q2x;
    end
    if (dy < 0) begin
      q1y = -q1y;
      q2y = -q2y;
    end
    sat = 1'b0;
    r.v1x = clamp_vel(longint'($signed(in_first_vel_x)) + q1x, sat);
    r.v1y = clamp_vel(longint'($signed(in_first_vel_y)) + q1y, sat);
    r.v2x = clamp_vel(longint'($signed(in_second_vel_x)) - q2x, sat);
    r.v2y = clamp_vel(longint'($signed(in_second_vel_y)) - q2y, sat);
    r.sat = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    kicked_vel_t want;
    kicked_vel_t got;
    if (!rst_n) begin
      grav_q <= G_RESET;
      step_q <= DT_RESET;
      soft_q <= EPS_RESET;
      mismatches <= 0;
      kicks_pending <= 0;
      kick_queue.delete();
    end else begin
      // register writes; unknown indexes fall through
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_GRAV: grav_q <= pwdata;
          REG_STEP: step_q <= pwdata;
          REG_SOFT: soft_q <= pwdata[16:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) kick_queue.insert(kick_queue.size(), predict_kick());
      // compare a result transfer with the oldest prediction
      if (out_valid && !out_stall) begin
        got = '{out_new_first_vel_x, out_new_first_vel_y, out_new_second_vel_x,
                out_new_second_vel_y, out_saturated};
        if (kick_queue.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transfer: %p", got);
          mismatches <= mismatches + 1;
        end else begin
          want = kick_queue.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("result mismatch: expected %p actual %p", want, got);
            mismatches <= mismatches + 1;
          end
        end
      end
      kicks_pending <= kick_queue.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// Stimulus and verdict for pairwise_gravity_kick_core: bursty pair traffic,
// patterned result stalls and register phases; checking lives in gravity_kick_checker.
// Depends on pgk_pkg, pairwise_gravity_kick_core and gravity_kick_checker.
module tb_top;
  import pgk_pkg::*;

  typedef struct {
    logic [31:0] x1, y1, vx1, vy1, m1, x2, y2, vx2, vy2, m2;
  } body_pair_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid, in_stall;
  logic [31:0] in_first_x, in_first_y, in_first_vel_x, in_first_vel_y, in_first_mass;
  logic [31:0] in_second_x, in_second_y, in_second_vel_x, in_second_vel_y, in_second_mass;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_new_first_vel_x, out_new_first_vel_y;
  logic [31:0] out_new_second_vel_x, out_new_second_vel_y;
  logic out_saturated;
  int mismatches;
  int kicks_pending;
  int burst_left;
  int idle_cycles = 0;
  int cyc = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pairwise_gravity_kick_core DUT (.*);
  gravity_kick_checker u_checker (.*);

  // result-side stall pattern, its character chosen by bits 9:8 of the cycle counter
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case (cyc[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 99) < 40);
      2'd2: out_stall <= (cyc[2:0] == 3'd0);
      default: out_stall <= cyc[4];
    endcase
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // let the pipeline empty before touching registers
  task automatic drain();
    while (kicks_pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic push_pair(body_pair_t p);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_first_x <= p.x1;
    in_first_y <= p.y1;
    in_first_vel_x <= p.vx1;
    in_first_vel_y <= p.vy1;
    in_first_mass <= p.m1;
    in_second_x <= p.x2;
    in_second_y <= p.y2;
    in_second_vel_x <= p.vx2;
    in_second_vel_y <= p.vy2;
    in_second_mass <= p.m2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // mostly close pairs so kicks matter; the rest fully random
  function automatic body_pair_t random_pair();
    body_pair_t p;
    int unsigned span;
    p = '{$urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 9) < 7) begin
      span = $urandom_range(2, 24);
      p.x1 = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
      p.y1 = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
      p.x2 = p.x1 + $urandom_range(0, 1 << span) - (1 << (span - 1));
      p.y2 = p.y1 + $urandom_range(0, 1 << span) - (1 << (span - 1));
      if ($urandom_range(0, 3) != 0) begin
        p.vx1 = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        p.vy1 = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        p.vx2 = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        p.vy2 = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      end
      if ($urandom_range(0, 1)) p.m1 = $urandom_range(1, 1 << 20);
      if ($urandom_range(0, 1)) p.m2 = $urandom_range(1, 1 << 20);
    end
    if (p.m1 == 0) p.m1 = 1;
    if (p.m2 == 0) p.m2 = 1;
    return p;
  endfunction

  logic [31:0] grav_set[7] = '{32'd6553600, 32'hFFFF_FFFF, 32'd0, 32'd65536,
                               32'd6553600, 32'h1234_5678, 32'd1};
  logic [31:0] step_set[7] = '{32'd4294967, 32'hFFFF_FFFF, 32'd4294967, 32'd0,
                               32'd4294967, 32'h0010_0000, 32'hFFFF_FFFF};
  logic [31:0] soft_set[7] = '{32'd6554, 32'd65536, 32'd6554, 32'd6554,
                               32'd0, 32'h1_FFFF, 32'd1};

  initial begin
    body_pair_t p;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    {in_first_x, in_first_y, in_first_vel_x, in_first_vel_y, in_first_mass} <= '0;
    {in_second_x, in_second_y, in_second_vel_x, in_second_vel_y, in_second_mass} <= '0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pairs at reset settings
    push_pair('{0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0, 0, 32'h10000});
    push_pair('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF});
    push_pair('{32'h8000_0000, 32'h8000_0000, 0, 0, 1,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1});
    // coincident bodies, heavy: zero separation gives a zero kick
    push_pair('{32'h50000, 32'h50000, 32'h7FFF_0000, 32'h8000_1000, 32'hFFFF_FFFF,
                32'h50000, 32'h50000, 32'h8000_1000, 32'h7FFF_0000, 32'hFFFF_FFFF});
    push_pair('{0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000,
                32'h1000, 32'hFFFF_F000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000});
    // zero mass on one side
    push_pair('{0, 0, 32'h100, 32'h100, 0, 32'h8000, 32'h8000, 32'h200, 32'h200, 32'h10000});
    push_pair('{32'h1_0000, 32'hFFFF_0000, 0, 0, 32'h100_0000,
                32'hFFFF_0000, 32'h1_0000, 0, 0, 32'h100_0000});
    push_pair('{32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1, 32'h8000_0000,
                0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'h8000_0000});

    // register phases, extremes among them
    for (int ph = 0; ph < 7; ph++) begin
      in_valid <= 1'b0;
      drain();
      reg_write(4'd0, grav_set[ph]);
      reg_write(4'd4, step_set[ph]);
      reg_write(4'd8, soft_set[ph]);
      // write to a register slot past the list; must have no effect
      reg_write(4'd12, $urandom);
      if (ph == 4) begin
        // coincident bodies with no softening
        push_pair('{32'h3000, 32'h7000, 32'h10, 32'h20, 32'hFFFF_FFFF,
                    32'h3000, 32'h7000, 32'h30, 32'h40, 32'hFFFF_FFFF});
      end
      for (int n = 0; n < 70; n++) begin
        p = random_pair();
        push_pair(p);
      end
    end
    in_valid <= 1'b0;

    while (kicks_pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/pgk_pkg.sv
sv/pgk_isqrt.sv
sv/pgk_div.sv
sv/pairwise_gravity_kick_core.sv
tb/gravity_kick_checker.sv
tb/tb_top.sv
